@@ rtl/pcpl_pkg.sv @@
// Shared types and constants for the per-channel peak limiter.
`default_nettype none

package pcpl_pkg;

	// Field widths
	localparam int SAMPLE_W = 16;
	localparam int CHAN_W   = 3;
	localparam int GAIN_W   = 16;
	localparam int COEFF_W  = 16;
	localparam int TDATA_W  = 24;

	// Configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	// Divider: Q1.30 limit over a 16-bit magnitude
	localparam int DIVIDEND_W = 31;
	localparam int DIVISOR_W  = 16;
	localparam int DIV_CNT_W  = 5;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_LIMIT  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEFF = 4'd1;

	// Reset values and unity gain (Q1.15)
	localparam logic [GAIN_W-1:0]  UNITY_GAIN        = 16'h8000;
	localparam logic [GAIN_W-1:0]  LIMIT_RESET       = 16'h8000;
	localparam logic [COEFF_W-1:0] COEFF_RESET       = 16'd65508;

endpackage : pcpl_pkg

`default_nettype wire

@@ rtl/pcpl_div.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module pcpl_div (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   start,
	input  wire  [pcpl_pkg::DIVIDEND_W-1:0]       dividend,
	input  wire  [pcpl_pkg::DIVISOR_W-1:0]        divisor,
	output logic                                  busy,
	output logic [pcpl_pkg::DIVIDEND_W-1:0]       quotient
);
	import pcpl_pkg::*;

	logic                   busy_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic [DIVIDEND_W-1:0]  quo_q;
	logic [DIVISOR_W-1:0]   rem_q;
	logic [DIVISOR_W-1:0]   dsr_q;
	logic [DIVISOR_W:0]     trial;
	logic [DIVISOR_W+1:0]   diff;
	logic                   fits;

	// Trial subtract of the shifted remainder
	always_comb begin
		trial = {rem_q, quo_q[DIVIDEND_W-1]};
		diff  = {1'b0, trial} - {2'b00, dsr_q};
		fits  = ~diff[DIVISOR_W+1];
	end

	// Control: step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIVIDEND_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath: dividend bits shift out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule : pcpl_div

`default_nettype wire

@@ rtl/pcpl_gain_mem.sv @@
// Per-channel gain memory with unity default until an entry is written.
`default_nettype none

module pcpl_gain_mem #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               rd_en,
	input  wire  [AW-1:0]                     rd_addr,
	output logic [pcpl_pkg::GAIN_W-1:0]       rd_gain,
	input  wire                               wr_en,
	input  wire  [AW-1:0]                     wr_addr,
	input  wire  [pcpl_pkg::GAIN_W-1:0]       wr_gain
);
	import pcpl_pkg::*;

	logic [GAIN_W-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [GAIN_W-1:0] rd_data_q;
	logic              rd_valid_q;

	// Storage array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_gain;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// Written marks, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_gain = rd_valid_q ? rd_data_q : UNITY_GAIN;

endmodule : pcpl_gain_mem

`default_nettype wire

@@ rtl/per_channel_peak_limiter_core.sv @@
// Top level of the per-channel peak limiter: handshakes, control and gain update.
`default_nettype none

// Peak limiter with instant attack and exponential release, one Q1.15 gain per
// channel held in a small memory (unity after reset). An item is one sample and
// its channel; each yields one result, the sample times the updated gain. Items
// are handled one at a time: an item passes from acceptance to its result through
// gain read, a 31-step bit-serial divider for limit/|x|, gain write-back and
// output multiply; the result is loaded once the output register is free, and the
// next item can be taken in the cycle after the result is loaded.
// A finished result sits in the output register while the next item is taken.
// Channels at or above NUM_CHANNELS pass the sample through untouched.
// Configuration writes are accepted every cycle and should be made while idle.
module per_channel_peak_limiter_core #(
	parameter int NUM_CHANNELS = 8
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// Input stream; s_tdata: [15:0] sample_in, [18:16] chan_in, rest zero
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	input  wire  [pcpl_pkg::TDATA_W-1:0]        s_tdata,
	// Result stream; m_tdata: [15:0] sample_out, [18:16] chan_out, rest zero
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	output logic [pcpl_pkg::TDATA_W-1:0]        m_tdata,
	// Configuration write channel
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [pcpl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [pcpl_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import pcpl_pkg::*;

	localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_READ = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_OMUL = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [GAIN_W-1:0]  limit_q;
	logic [COEFF_W-1:0] coeff_q;
	logic [GAIN_W-1:0]  limit_eff;
	logic [DIVIDEND_W-1:0] lim_q30;

	// Input decode
	logic [SAMPLE_W-1:0] in_sample;
	logic [CHAN_W-1:0]   in_chan;
	logic [SAMPLE_W-1:0] in_mag;
	logic                in_range;
	logic                accept;

	// Item registers
	logic [SAMPLE_W-1:0] sample_q;
	logic [CHAN_W-1:0]   chan_q;
	logic [SAMPLE_W-1:0] mag_q;
	logic                neg_q;
	logic                range_q;

	// Products and gain
	logic [GAIN_W-1:0]   gain_old;
	logic [GAIN_W-1:0]   gain_clamp;
	logic [2*GAIN_W-1:0] prod_q;
	logic [2*GAIN_W-1:0] relmul_q;
	logic [2*GAIN_W-1:0] ymul_q;
	logic [GAIN_W-1:0]   gain_new;
	logic [GAIN_W-1:0]   gain_new_q;
	logic [GAIN_W-1:0]   rel_gain;
	logic                attack;
	logic                gain_wr_en;

	// Divider
	logic                  div_busy;
	logic [DIVIDEND_W-1:0] div_quot;

	// Output
	logic [SAMPLE_W-1:0] ymag;
	logic [SAMPLE_W-1:0] y_val;
	logic                out_free;
	logic                m_tvalid_q;
	logic [TDATA_W-1:0]  m_tdata_q;

	// Config writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			coeff_q <= COEFF_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SIGNAL_LIMIT:  limit_q <= cfg_data;
				REG_RELEASE_COEFF: coeff_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Limit clamped to unity, scaled to Q1.30
	assign limit_eff = (limit_q > UNITY_GAIN) ? UNITY_GAIN : limit_q;
	assign lim_q30   = {limit_eff, 15'd0};

	// Input decode and handshake
	assign in_sample = s_tdata[SAMPLE_W-1:0];
	assign in_chan   = s_tdata[SAMPLE_W +: CHAN_W];
	assign in_mag    = in_sample[SAMPLE_W-1] ? (SAMPLE_W'(0) - in_sample) : in_sample;
	assign in_range  = (32'(in_chan) < NUM_CHANNELS);
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;

	// Gain memory
	pcpl_gain_mem #(
		.DEPTH (NUM_CHANNELS),
		.AW    (AW)
	) u_gain_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && in_range),
		.rd_addr (AW'(in_chan)),
		.rd_gain (gain_old),
		.wr_en   (gain_wr_en),
		.wr_addr (AW'(chan_q)),
		.wr_gain (gain_new)
	);

	// Cap divider, started on acceptance
	pcpl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.dividend (lim_q30),
		.divisor  (in_mag),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	// Gain update once the cap is known
	always_comb begin
		attack   = (prod_q > {1'b0, lim_q30});
		rel_gain = UNITY_GAIN - relmul_q[2*GAIN_W-1:GAIN_W];
		if (attack) begin
			gain_new = div_quot[GAIN_W-1:0];
		end else if ((mag_q != '0) && (div_quot < DIVIDEND_W'(rel_gain))) begin
			gain_new = div_quot[GAIN_W-1:0];
		end else begin
			gain_new = rel_gain;
		end
	end

	assign gain_clamp = (gain_old > UNITY_GAIN) ? UNITY_GAIN : gain_old;
	assign gain_wr_en = (state_q == ST_DIV) && !div_busy && range_q;

	// Output sample from the product with the new gain
	assign ymag     = ymul_q[2*GAIN_W-2:GAIN_W-1];
	assign y_val    = !range_q ? sample_q : (neg_q ? (SAMPLE_W'(0) - ymag) : ymag);
	assign out_free = !m_tvalid_q || m_tready;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_READ;
				ST_READ: state_q <= ST_DIV;
				ST_DIV:  if (!div_busy) state_q <= ST_OMUL;
				ST_OMUL: state_q <= ST_DONE;
				ST_DONE: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= in_sample;
			chan_q   <= in_chan;
			mag_q    <= in_mag;
			neg_q    <= in_sample[SAMPLE_W-1];
			range_q  <= in_range;
		end
		if (state_q == ST_READ) begin
			prod_q   <= (2*GAIN_W)'(mag_q) * (2*GAIN_W)'(gain_old);
			relmul_q <= (2*GAIN_W)'(coeff_q) * (2*GAIN_W)'(UNITY_GAIN - gain_clamp);
		end
		if ((state_q == ST_DIV) && !div_busy) begin
			gain_new_q <= gain_new;
		end
		if (state_q == ST_OMUL) begin
			ymul_q <= (2*GAIN_W)'(mag_q) * (2*GAIN_W)'(gain_new_q);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			m_tdata_q <= {{(TDATA_W-SAMPLE_W-CHAN_W){1'b0}}, chan_q, y_val};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef ASSERT_OFF
	// An item never arrives while the divider is still working on the last one
	a_div_idle_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !div_busy)
		else $error("item accepted while divider busy");

	// The divider starts on every accepted item
	a_div_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> div_busy)
		else $error("divider did not start");

	// A stored gain never exceeds unity
	a_gain_le_unity: assert property (@(posedge clk) disable iff (!arst_n)
		gain_wr_en |-> (gain_new <= UNITY_GAIN))
		else $error("gain above unity written");

	// A result is loaded only when the output register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata))
		else $error("pending result overwritten");
`endif

endmodule : per_channel_peak_limiter_core

`default_nettype wire
